/* hw/rtl/bba_pkg.sv */
`default_nettype none

package bba_pkg;

    // Tree geometry: one node per block of every order, heap ordered.
    localparam int TREE_ORDER = 10;
    localparam int NODES      = (2 << TREE_ORDER) - 1;
    localparam int IDX_W      = $clog2(NODES);
    localparam int ORD_W      = 4;
    localparam int OFF_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int MASK_W     = TREE_ORDER + 1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_FREE  = 2'd2,
        ST_NOT_HELD = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_INIT,
        S_IDLE,
        S_ATOP,
        S_DESC,
        S_WALK,
        S_WPAR,
        S_FCHK,
        S_MRG,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                action;
        logic [SIZE_W-1:0]   req_size;
        logic [OFF_W-1:0]    block_offset;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFF_W-1:0]    result_offset;
        logic [ORD_W-1:0]    result_order;
        logic [SIZE_W-1:0]   used_units;
    } t_out_word;

    // One tree node: allocated flag and the set of orders of free blocks in its subtree.
    typedef struct packed {
        logic                alloc;
        logic [MASK_W-1:0]   mask;
    } t_entry;

    typedef struct packed {
        logic                re;
        logic [IDX_W-1:0]    raddr;
        logic                we;
        logic [IDX_W-1:0]    waddr;
        t_entry              wdata;
    } t_mem_req;

    // Node index of the block of order o at offset off.
    function automatic logic [IDX_W-1:0] node_idx(input logic [ORD_W-1:0] o,
                                                  input logic [OFF_W-1:0] off);
        logic [IDX_W-1:0] base;
        base = (IDX_W'(1) << (ORD_W'(TREE_ORDER) - o)) - IDX_W'(1);
        return base + IDX_W'(off >> o);
    endfunction

    // Smallest order whose block holds s units (s nonzero).
    function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] m;
        logic [ORD_W-1:0]  r;
        m = s - SIZE_W'(1);
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (m[i]) begin
                r = ORD_W'(i + 1);
            end
        end
        return r;
    endfunction

    // Lowest set bit of a free-order mask.
    function automatic logic [ORD_W-1:0] low_bit(input logic [MASK_W-1:0] m);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = ORD_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] ord_bit(input logic [ORD_W-1:0] o);
        return MASK_W'(1) << o;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bba_tree_mem.sv */
`default_nettype none

module bba_tree_mem (
    input  wire                 i_clk,
    input  bba_pkg::t_mem_req   i_req,
    output bba_pkg::t_entry     o_rd_data
);
    import bba_pkg::*;

    t_entry r_mem [NODES];
    t_entry r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/buddy_block_allocator.sv */
`default_nettype none

// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   i_in_word  (action, size, offset)
// output    out        o_out_valid / i_out_stall o_out_word (status, offset, order, used)
// config    in         i_cfg_we                  i_cfg_data (total_order)
//
// One word is handled at a time, and no new word is taken until the result of the last one
// is in the output register. The tree walk over the node memory sets how long a word takes:
// one read per level while descending or merging, and a sibling write or read plus a parent
// write per level while the path masks are rebuilt toward the root.
// After reset and after every configuration write a clearing pass sweeps the node memory;
// no input word is taken during it.
// A finished result waits in the output register, and the next word is taken meanwhile.

module buddy_block_allocator (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  bba_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output bba_pkg::t_out_word   o_out_word,
    input  wire                  i_cfg_we,
    input  wire [3:0]            i_cfg_data
);
    import bba_pkg::*;

    t_state             r_state, n_state;
    logic [ORD_W-1:0]   r_tord, n_tord;
    logic [SIZE_W-1:0]  r_units, n_units;
    logic [IDX_W-1:0]   r_clr, n_clr;
    logic [ORD_W-1:0]   r_req, n_req;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [ORD_W-1:0]   r_lvl, n_lvl;
    logic [ORD_W-1:0]   r_fo, n_fo;
    logic [MASK_W-1:0]  r_mask, n_mask;
    logic [MASK_W-1:0]  r_sib, n_sib;
    logic               r_usemem, n_usemem;
    t_status            r_st, n_st;
    logic [ORD_W-1:0]   r_rord, n_rord;
    logic [OFF_W-1:0]   r_roff, n_roff;
    logic               r_ov, n_ov;
    t_out_word          r_ow, n_ow;

    t_mem_req           mreq;
    t_entry             rd;
    logic               in_acc;
    logic               out_free;

    bba_tree_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mreq),
        .o_rd_data (rd)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_tord  <= ORD_W'(TREE_ORDER);
            r_units <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tord  <= n_tord;
            r_units <= n_units;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_off    <= n_off;
        r_lvl    <= n_lvl;
        r_fo     <= n_fo;
        r_mask   <= n_mask;
        r_sib    <= n_sib;
        r_usemem <= n_usemem;
        r_st     <= n_st;
        r_rord   <= n_rord;
        r_roff   <= n_roff;
        r_ow     <= n_ow;
    end

    // Sequencer: next state, memory accesses and results.
    always_comb begin
        logic [ORD_W-1:0]  req_c;
        logic [ORD_W-1:0]  c;
        logic [OFF_W-1:0]  noff;
        logic [MASK_W-1:0] cand;
        logic [MASK_W-1:0] sib;
        logic [MASK_W-1:0] pm;
        logic [ORD_W-1:0]  fo;
        logic [ORD_W-1:0]  nl;

        n_state  = r_state;
        n_tord   = r_tord;
        n_units  = r_units;
        n_clr    = r_clr;
        n_req    = r_req;
        n_off    = r_off;
        n_lvl    = r_lvl;
        n_fo     = r_fo;
        n_mask   = r_mask;
        n_sib    = r_sib;
        n_usemem = r_usemem;
        n_st     = r_st;
        n_rord   = r_rord;
        n_roff   = r_roff;
        n_ov     = r_ov && i_out_stall;
        n_ow     = r_ow;
        mreq     = '0;

        req_c = size_order(i_in_word.req_size);
        c     = r_lvl - ORD_W'(1);
        noff  = '0;
        cand  = '0;
        sib   = '0;
        pm    = '0;
        fo    = '0;
        nl    = r_lvl + ORD_W'(1);

        unique case (r_state)
            S_CLEAR: begin
                mreq.we    = 1'b1;
                mreq.waddr = r_clr;
                if (r_clr == IDX_W'(NODES - 1)) begin
                    n_state = S_INIT;
                end else begin
                    n_clr = r_clr + IDX_W'(1);
                end
            end

            S_INIT: begin
                mreq.we    = 1'b1;
                mreq.waddr = node_idx(r_tord, '0);
                mreq.wdata = '{alloc: 1'b0, mask: ord_bit(r_tord)};
                n_units    = '0;
                n_state    = S_IDLE;
            end

            S_IDLE: begin
                if (in_acc) begin
                    n_req  = req_c;
                    n_rord = req_c;
                    n_roff = '0;
                    if (i_in_word.req_size == '0 || req_c > r_tord) begin
                        n_st    = ST_BAD_SIZE;
                        n_rord  = '0;
                        n_state = S_DONE;
                    end else if (i_in_word.action == ACT_ALLOC) begin
                        n_off      = '0;
                        mreq.re    = 1'b1;
                        mreq.raddr = node_idx(r_tord, '0);
                        n_state    = S_ATOP;
                    end else if ((i_in_word.block_offset >> r_tord) != '0 ||
                                 (i_in_word.block_offset &
                                  ((OFF_W'(1) << req_c) - OFF_W'(1))) != '0) begin
                        n_st    = ST_NOT_HELD;
                        n_state = S_DONE;
                    end else begin
                        n_off      = i_in_word.block_offset;
                        n_roff     = i_in_word.block_offset;
                        mreq.re    = 1'b1;
                        mreq.raddr = node_idx(req_c, i_in_word.block_offset);
                        n_state    = S_FCHK;
                    end
                end
            end

            // Pick the smallest order with a free block at or above the request.
            S_ATOP: begin
                cand = rd.mask & ~((MASK_W'(1) << r_req) - MASK_W'(1));
                fo   = low_bit(cand);
                n_fo = fo;
                if (cand == '0) begin
                    n_st    = ST_NO_FREE;
                    n_state = S_DONE;
                end else if (fo == r_tord) begin
                    mreq.we    = 1'b1;
                    mreq.waddr = node_idx(r_req, '0);
                    mreq.wdata = '{alloc: 1'b1, mask: '0};
                    n_units    = r_units + (SIZE_W'(1) << r_req);
                    n_mask     = '0;
                    n_lvl      = r_req;
                    n_st       = ST_OK;
                    n_roff     = '0;
                    n_state    = (r_req == r_tord) ? S_DONE : S_WALK;
                end else begin
                    n_lvl      = r_tord;
                    mreq.re    = 1'b1;
                    mreq.raddr = node_idx(r_tord - ORD_W'(1), '0);
                    n_state    = S_DESC;
                end
            end

            // Descend toward the lowest free block of the chosen order.
            S_DESC: begin
                noff  = rd.mask[r_fo] ? r_off : (r_off | (OFF_W'(1) << c));
                n_off = noff;
                n_lvl = c;
                if (c == r_fo) begin
                    mreq.we    = 1'b1;
                    mreq.waddr = node_idx(r_req, noff);
                    mreq.wdata = '{alloc: 1'b1, mask: '0};
                    n_units    = r_units + (SIZE_W'(1) << r_req);
                    n_mask     = '0;
                    n_lvl      = r_req;
                    n_st       = ST_OK;
                    n_roff     = noff;
                    n_state    = S_WALK;
                end else begin
                    mreq.re    = 1'b1;
                    mreq.raddr = node_idx(c - ORD_W'(1), noff);
                end
            end

            // Sibling on the path: fresh upper half inside a split, else read it.
            S_WALK: begin
                if (r_lvl < r_fo) begin
                    mreq.we    = 1'b1;
                    mreq.waddr = node_idx(r_lvl, r_off ^ (OFF_W'(1) << r_lvl));
                    mreq.wdata = '{alloc: 1'b0, mask: ord_bit(r_lvl)};
                    n_sib      = ord_bit(r_lvl);
                    n_usemem   = 1'b0;
                end else begin
                    mreq.re    = 1'b1;
                    mreq.raddr = node_idx(r_lvl, r_off ^ (OFF_W'(1) << r_lvl));
                    n_usemem   = 1'b1;
                end
                n_state = S_WPAR;
            end

            // Parent mask is the union of both children.
            S_WPAR: begin
                sib        = r_usemem ? rd.mask : r_sib;
                pm         = r_mask | sib;
                mreq.we    = 1'b1;
                mreq.waddr = node_idx(nl, r_off);
                mreq.wdata = '{alloc: 1'b0, mask: pm};
                n_mask     = pm;
                n_lvl      = nl;
                n_state    = (nl == r_tord) ? S_DONE : S_WALK;
            end

            // Free: the block must be allocated at exactly this order.
            S_FCHK: begin
                if (!rd.alloc) begin
                    n_st    = ST_NOT_HELD;
                    n_roff  = '0;
                    n_state = S_DONE;
                end else begin
                    n_st       = ST_OK;
                    n_units    = r_units - (SIZE_W'(1) << r_req);
                    n_lvl      = r_req;
                    n_fo       = '0;
                    mreq.we    = 1'b1;
                    mreq.waddr = node_idx(r_req, r_off);
                    if (r_req == r_tord) begin
                        mreq.wdata = '{alloc: 1'b0, mask: ord_bit(r_req)};
                        n_state    = S_DONE;
                    end else begin
                        mreq.wdata = '{alloc: 1'b0, mask: '0};
                        mreq.re    = 1'b1;
                        mreq.raddr = node_idx(r_req, r_off ^ (OFF_W'(1) << r_req));
                        n_state    = S_MRG;
                    end
                end
            end

            // Merge with free buddies until one is not free or the root is reached.
            S_MRG: begin
                if (rd.mask[r_lvl]) begin
                    noff  = r_off & ~(OFF_W'(1) << r_lvl);
                    n_off = noff;
                    n_lvl = nl;
                    if (nl == r_tord) begin
                        mreq.we    = 1'b1;
                        mreq.waddr = node_idx(nl, noff);
                        mreq.wdata = '{alloc: 1'b0, mask: ord_bit(nl)};
                        n_state    = S_DONE;
                    end else begin
                        mreq.re    = 1'b1;
                        mreq.raddr = node_idx(nl, noff ^ (OFF_W'(1) << nl));
                    end
                end else begin
                    mreq.we    = 1'b1;
                    mreq.waddr = node_idx(r_lvl, r_off);
                    mreq.wdata = '{alloc: 1'b0, mask: ord_bit(r_lvl)};
                    n_mask     = ord_bit(r_lvl);
                    n_sib      = rd.mask;
                    n_usemem   = 1'b0;
                    n_state    = S_WPAR;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ow    = '{status: r_st, result_offset: r_roff,
                                result_order: r_rord, used_units: r_units};
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // A configuration write restarts the pool.
        if (i_cfg_we) begin
            n_tord  = (i_cfg_data > 4'(TREE_ORDER)) ? ORD_W'(TREE_ORDER)
                                                    : ORD_W'(i_cfg_data);
            n_state = S_CLEAR;
            n_clr   = '0;
            n_units = '0;
        end
    end

`ifndef SYNTHESIS
    // The node memory is never read and written at the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mreq.we && mreq.re && mreq.waddr == mreq.raddr))
        else $error("node memory read and write collide");

    // Units in use never exceed the pool.
    a_units_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_units <= (SIZE_W'(1) << r_tord)))
        else $error("units in use exceed pool size");

    // A finished word reaches the output register.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && !i_cfg_we) |=> o_out_valid)
        else $error("result lost");

    // A successful result names an aligned block.
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_OK) |->
        ((o_out_word.result_offset &
          ((OFF_W'(1) << o_out_word.result_order) - OFF_W'(1))) == '0))
        else $error("result block misaligned");

    // The path rebuild stays below the pool root.
    a_walk_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WPAR) |-> (r_lvl < r_tord))
        else $error("path walk past root");
`endif

endmodule

`default_nettype wire

/* test/buddy_block_checker.sv */
`timescale 1ns / 100ps

module buddy_block_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  bba_pkg::t_in_word   i_in_word,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  bba_pkg::t_out_word  i_out_word,
    input  wire                 i_cfg_we,
    input  wire [3:0]           i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import bba_pkg::*;

    localparam int NODE_CNT = (2 << TREE_ORDER) - 1;

    // Shadow copy of the buddy tree.
    bit          free_map [NODE_CNT];
    bit          held_map [NODE_CNT];
    int unsigned pool_order;
    int unsigned units_used;
    t_out_word   expected_q [$];

    assign o_pending = expected_q.size();

    function automatic int unsigned tree_node(int unsigned o, int unsigned off);
        int unsigned idx;
        idx = ((1 << (TREE_ORDER - o)) - 1) + (off >> o);
        return (idx < NODE_CNT) ? idx : 0;
    endfunction

    function automatic int unsigned round_order(int unsigned s);
        int unsigned o;
        o = 0;
        while ((1 << o) < s) o++;
        return o;
    endfunction

    function automatic void reset_pool(int unsigned ord);
        pool_order = (ord > TREE_ORDER) ? TREE_ORDER : ord;
        foreach (free_map[i]) begin
            free_map[i] = 0;
            held_map[i] = 0;
        end
        units_used = 0;
        free_map[tree_node(pool_order, 0)] = 1;
    endfunction

    function automatic t_out_word make_result(t_status st, int unsigned off, int unsigned ord);
        t_out_word w;
        w.status        = st;
        w.result_offset = OFF_W'(off);
        w.result_order  = ORD_W'(ord);
        w.used_units    = SIZE_W'(units_used);
        return w;
    endfunction

    // Apply one request to the shadow tree and return the expected result.
    function automatic t_out_word apply_request(t_in_word w);
        int unsigned sz, off, req, o, k, at, cur, bud;
        bit          found;
        sz  = w.req_size;
        off = w.block_offset;
        if (sz == 0) return make_result(ST_BAD_SIZE, 0, 0);
        req = round_order(sz);
        if (req > pool_order) return make_result(ST_BAD_SIZE, 0, 0);
        if (w.action == ACT_ALLOC) begin
            found = 0;
            at    = 0;
            for (o = req; o <= pool_order && !found; o++) begin
                for (k = 0; k < (1 << (pool_order - o)); k++) begin
                    if (free_map[tree_node(o, k << o)]) begin
                        at    = k << o;
                        found = 1;
                        break;
                    end
                end
            end
            if (!found) return make_result(ST_NO_FREE, 0, req);
            o--;
            free_map[tree_node(o, at)] = 0;
            // Split down, leaving every upper half free.
            while (o > req) begin
                o--;
                free_map[tree_node(o, at + (1 << o))] = 1;
            end
            held_map[tree_node(req, at)] = 1;
            units_used = (units_used + (1 << req)) & 'h7FF;
            return make_result(ST_OK, at, req);
        end
        if ((off >> pool_order) != 0 || (off & ((1 << req) - 1)) != 0
                || !held_map[tree_node(req, off)])
            return make_result(ST_NOT_HELD, 0, req);
        held_map[tree_node(req, off)] = 0;
        units_used = (units_used - (1 << req)) & 'h7FF;
        // Merge upward while the buddy is free.
        cur = off;
        o   = req;
        while (o < pool_order) begin
            bud = cur ^ (1 << o);
            if (!free_map[tree_node(o, bud)]) break;
            free_map[tree_node(o, bud)] = 0;
            cur &= ~(1 << o);
            o++;
        end
        free_map[tree_node(o, cur)] = 1;
        return make_result(ST_OK, off, req);
    endfunction

    initial begin
        reset_pool(10);
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            reset_pool(10);
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) reset_pool(i_cfg_data);
            if (i_in_valid && !i_in_stall) expected_q.push_back(apply_request(i_in_word));
            // Compare each accepted result word with the oldest expectation.
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result word %h", i_out_word);
                    errs++;
                end else begin
                    exp_w = expected_q.pop_front();
                    if (exp_w.status !== i_out_word.status) begin
                        $error("status: expected %0d, actual %0d", exp_w.status,
                               i_out_word.status);
                        errs++;
                    end
                    if (exp_w.result_offset !== i_out_word.result_offset) begin
                        $error("result_offset: expected %0d, actual %0d",
                               exp_w.result_offset, i_out_word.result_offset);
                        errs++;
                    end
                    if (exp_w.result_order !== i_out_word.result_order) begin
                        $error("result_order: expected %0d, actual %0d",
                               exp_w.result_order, i_out_word.result_order);
                        errs++;
                    end
                    if (exp_w.used_units !== i_out_word.used_units) begin
                        $error("used_units: expected %0d, actual %0d",
                               exp_w.used_units, i_out_word.used_units);
                        errs++;
                    end
                end
            end
            if (errs != 0) begin
                o_fail_count <= o_fail_count + errs;
            end
        end
    end

endmodule

/* test/tb_buddy_block_allocator.sv */
`timescale 1ns / 100ps

module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 2 * TREE_ORDER + 10;
    localparam int  CLEAR_WAIT  = (2 << TREE_ORDER) + 20;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       in_valid = 0;
    logic       in_stall;
    t_in_word   in_word = '0;
    logic       out_valid;
    logic       out_stall = 0;
    t_out_word  out_word;
    logic       cfg_we = 0;
    logic [3:0] cfg_data = 4'd10;
    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    bit         calm = 0;
    int unsigned cur_order = 10;

    always #6 i_clk = ~i_clk;

    buddy_block_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    buddy_block_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver stalls at random except during calm stretches.
    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(99) < 25);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one word and hold it until it is accepted; valid stays up afterwards
    // until the next idle cycle or the next word replaces it.
    task automatic send_word(bit act, int unsigned sz, int unsigned off);
        while (!calm && $urandom_range(99) < 25) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        in_word.action       <= act;
        in_word.req_size     <= SIZE_W'(sz);
        in_word.block_offset <= OFF_W'(off);
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_pool_order(int unsigned ord);
        drain_results();
        cfg_we   <= 1;
        cfg_data <= 4'(ord);
        @(posedge i_clk);
        cfg_we <= 0;
        cur_order = (ord > TREE_ORDER) ? TREE_ORDER : ord;
    endtask

    task automatic random_phase(int count);
        int idx;
        int unsigned r;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_word(ACT_ALLOC, $urandom_range(1 << $urandom_range(cur_order), 1),
                          $urandom_range(1023));
            end else if (r < 90) begin
                // Free a guessed block that may or may not be held; offsets are
                // aligned guesses over the pool.
                idx = $urandom_range(cur_order);
                send_word(ACT_FREE, (1 << idx) - ($urandom_range(1) ? 0 : ((1 << idx) >> 1)),
                          ($urandom_range((1 << cur_order) - 1) >> idx) << idx);
            end else begin
                send_word($urandom_range(1), $urandom_range(2047), $urandom_range(1023));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (CLEAR_WAIT) @(posedge i_clk);

        // Directed: extremes, errors and a split-then-merge sequence.
        calm = 1;
        send_word(ACT_ALLOC, 0, 0);
        send_word(ACT_ALLOC, 1025, 0);
        send_word(ACT_ALLOC, 2047, 1023);
        send_word(ACT_FREE, 1, 0);
        send_word(ACT_ALLOC, 1, 1023);
        send_word(ACT_ALLOC, 3, 0);
        send_word(ACT_ALLOC, 512, 0);
        send_word(ACT_ALLOC, 512, 0);
        send_word(ACT_FREE, 4, 2);
        send_word(ACT_FREE, 4, 4);
        send_word(ACT_FREE, 1, 0);
        send_word(ACT_FREE, 1, 0);
        send_word(ACT_FREE, 512, 512);
        send_word(ACT_ALLOC, 1024, 0);
        send_word(ACT_ALLOC, 256, 0);
        send_word(ACT_ALLOC, 256, 0);
        send_word(ACT_FREE, 256, 768);
        send_word(ACT_FREE, 1024, 0);
        calm = 0;

        set_pool_order(0);
        send_word(ACT_ALLOC, 1, 0);
        send_word(ACT_ALLOC, 2, 0);
        send_word(ACT_ALLOC, 1, 0);
        send_word(ACT_FREE, 1, 0);
        set_pool_order(15);
        send_word(ACT_ALLOC, 1024, 0);
        send_word(ACT_FREE, 1024, 0);
        in_valid <= 0;
        repeat (CLEAR_WAIT) @(posedge i_clk);

        // Random phases across several pool sizes, draining before every size change.
        set_pool_order(3);
        random_phase(200);
        drain_results();
        set_pool_order(10);
        random_phase(300);
        calm = 1;
        random_phase(150);
        calm = 0;
        set_pool_order(1);
        random_phase(100);
        set_pool_order(6);
        random_phase(250);
        set_pool_order(2);
        random_phase(150);
        set_pool_order(10);
        random_phase(100);

        drain_results();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bba_pkg.sv
hw/rtl/bba_tree_mem.sv
hw/rtl/buddy_block_allocator.sv
test/buddy_block_checker.sv
test/tb_buddy_block_allocator.sv
